// ----- design/plir_pkg.sv -----
`timescale 1ns / 1ps

package plir_pkg;

   localparam int SampleBits = 16;
   localparam int RateBits   = 18;
   localparam int PhaseBits  = RateBits + 1;
   localparam int MaxResults = 48;
   localparam int CountBits  = $clog2(MaxResults + 1);
   // Products of a sample and a phase weight, and their sum.
   localparam int ProdBits   = SampleBits + PhaseBits;
   // Magnitude of the weighted sum stays below 2^(SampleBits-1) * 2^RateBits.
   localparam int MagBits    = SampleBits - 1 + RateBits;
   localparam int QuotBits   = SampleBits;
   localparam int AddrBits   = 3;
   localparam int DataBits   = 32;

   localparam logic [RateBits-1:0] InRateReset  = RateBits'(16000);
   localparam logic [RateBits-1:0] OutRateReset = RateBits'(16000);

   localparam logic RegInRate  = 1'b0;
   localparam logic RegOutRate = 1'b1;

   localparam int NumStdRates = 11;
   localparam logic [RateBits-1:0] StdRates [NumStdRates] = '{
      RateBits'(8000),  RateBits'(11025), RateBits'(16000), RateBits'(22050),
      RateBits'(32000), RateBits'(44100), RateBits'(48000), RateBits'(88200),
      RateBits'(96000), RateBits'(176400), RateBits'(192000)
   };

   localparam logic signed [SampleBits-1:0] SampleMax =
      {1'b0, {(SampleBits-1){1'b1}}};
   localparam logic signed [SampleBits-1:0] SampleMin =
      {1'b1, {(SampleBits-1){1'b0}}};

   typedef struct packed {
      logic [RateBits-1:0] in_rate;
      logic [RateBits-1:0] out_rate;
      logic                rates_ok;
   } cfg_type;

   typedef struct packed {
      logic signed [SampleBits-1:0] sample;
      logic                         stream_end;
      logic                         rate_error;
   } item_type;

   typedef struct packed {
      logic signed [SampleBits-1:0] sample_out;
      logic                         sample_valid;
      logic                         rate_error;
      logic                         last_out;
   } result_type;

   function automatic logic is_std_rate(input logic [RateBits-1:0] rate);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < NumStdRates; i++) begin
         if (rate == StdRates[i]) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

endpackage

// ----- design/pcm_linear_interp_resampler.sv -----
`timescale 1ns / 1ps

// Linear-interpolation resampler for signed mono PCM.
// Input words arrive on req_* (tdata = sample, tlast = end of stream) and
// resampled words leave on rsp_* (tdata = sample, tuser[0] = sample valid,
// tuser[1] = rate error, tlast = final word caused by that input word).
// input_rate (address 0) and output_rate (address 4) are set over csr_*;
// the user must set them only while the block is idle, which the block
// itself does not enforce. Both reset to 16000.
// A two-entry queue takes input words while the engine works and while a
// finished word waits in the output register; a stalled receiver holds the
// engine but not the queue until it fills.
// Each interpolated output takes one compare and one multiply (S_CHECK),
// one add (S_SUM), then the radix-2 divider by output_rate (S_DIV), the
// unit that sets the pace. Past 48 results per word, steps and copies are
// dropped while the phase walks on. The newest result waits until the
// next is known. Reset clears the held sample, the phase and both
// channels; no clearing pass is needed.

module pcm_linear_interp_resampler import plir_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [SampleBits-1:0] req_tdata,   // sample_in
   input  logic                  req_tlast,   // stream_end
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [SampleBits-1:0] rsp_tdata,   // sample_out
   output logic [1:0]            rsp_tuser,   // sample_valid, rate_error
   output logic                  rsp_tlast,   // last_out
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [AddrBits-1:0]   csr_paddr,
   input  logic [DataBits-1:0]   csr_pwdata,
   output logic [DataBits-1:0]   csr_prdata,
   output logic                  csr_pready
);

   cfg_type  cfg;
   logic     q_valid;
   item_type q_item;
   logic     q_pop;

   plir_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   plir_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   plir_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- design/plir_csr.sv -----
`timescale 1ns / 1ps

module plir_csr import plir_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [AddrBits-1:0] csr_paddr,
   input  logic [DataBits-1:0] csr_pwdata,
   output logic [DataBits-1:0] csr_prdata,
   output logic                csr_pready,
   output cfg_type             cfg
);

   logic [RateBits-1:0] in_rate_ff, in_rate_in;
   logic [RateBits-1:0] out_rate_ff, out_rate_in;
   logic                wr_en;
   logic                reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   // Registers sit on a 4-byte stride; bit 2 picks the register.
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      in_rate_in  = in_rate_ff;
      out_rate_in = out_rate_ff;
      if (wr_en) begin
         unique case (reg_sel)
            RegInRate:  in_rate_in  = csr_pwdata[RateBits-1:0];
            RegOutRate: out_rate_in = csr_pwdata[RateBits-1:0];
            default:    in_rate_in  = in_rate_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_rate_ff  <= InRateReset;
         out_rate_ff <= OutRateReset;
      end else begin
         in_rate_ff  <= in_rate_in;
         out_rate_ff <= out_rate_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         RegInRate:  csr_prdata = DataBits'(in_rate_ff);
         RegOutRate: csr_prdata = DataBits'(out_rate_ff);
         default:    csr_prdata = '0;
      endcase
   end

   assign cfg.in_rate  = in_rate_ff;
   assign cfg.out_rate = out_rate_ff;
   assign cfg.rates_ok = is_std_rate(out_rate_ff) && (in_rate_ff != '0);

endmodule

// ----- design/plir_front.sv -----
`timescale 1ns / 1ps

module plir_front import plir_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [SampleBits-1:0] req_tdata,   // sample_in
   input  logic                  req_tlast,   // stream_end
   output logic                  q_valid,
   output item_type              q_item,
   input  logic                  q_pop
);

   // Two-entry queue between the input channel and the engine.
   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   item_type   new_item;

   assign req_tready = (fill_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (fill_ff != 2'd0);
   assign q_item     = slot_ff[rd_ptr_ff];

   // An unsupported rate setting is decided here, when the word comes in.
   assign new_item.sample     = signed'(req_tdata);
   assign new_item.stream_end = req_tlast;
   assign new_item.rate_error = !cfg.rates_ok;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ----- design/plir_div.sv -----
`timescale 1ns / 1ps

module plir_div import plir_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [MagBits-1:0]  dividend,
   input  logic [RateBits-1:0] divisor,
   output logic                busy,
   output logic [QuotBits-1:0] quotient
);

   localparam int CntBits = $clog2(QuotBits + 1);

   logic [RateBits-1:0] rem_ff, rem_in;
   logic [QuotBits-1:0] shf_ff, shf_in;
   logic [RateBits-1:0] div_ff, div_in;
   logic [CntBits-1:0]  cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic [RateBits:0]   trial;
   logic                fits;

   // The dividend is below divisor * 2^QuotBits, so its upper part starts
   // out smaller than the divisor and only QuotBits steps remain.
   assign trial = {rem_ff, shf_ff[QuotBits-1]};
   assign fits  = (trial >= {1'b0, div_ff});

   always_comb begin
      rem_in  = rem_ff;
      shf_in  = shf_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = RateBits'(dividend[MagBits-1:QuotBits]);
         shf_in  = dividend[QuotBits-1:0];
         div_in  = divisor;
         cnt_in  = CntBits'(QuotBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? RateBits'(trial - {1'b0, div_ff}) : trial[RateBits-1:0];
         shf_in = {shf_ff[QuotBits-2:0], fits};
         cnt_in = cnt_ff - CntBits'(1);
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      shf_ff <= shf_in;
      div_ff <= div_in;
   end

   assign busy     = busy_ff;
   assign quotient = shf_ff;

endmodule

// ----- design/plir_back.sv -----
`timescale 1ns / 1ps

module plir_back import plir_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  q_valid,
   input  item_type              q_item,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [SampleBits-1:0] rsp_tdata,   // sample_out
   output logic [1:0]            rsp_tuser,   // sample_valid, rate_error
   output logic                  rsp_tlast    // last_out
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SUM,
      S_DIV,
      S_COPY,
      S_FINISH
   } state_type;

   state_type                    state_ff, state_in;
   logic signed [SampleBits-1:0] prev_ff, prev_in;
   logic signed [SampleBits-1:0] cur_ff, cur_in;
   logic                         have_ff, have_in;
   logic                         end_ff, end_in;
   logic [PhaseBits-1:0]         phase_ff, phase_in;
   logic [CountBits-1:0]         count_ff, count_in;
   logic signed [ProdBits-1:0]   p1_ff, p1_in;
   logic signed [ProdBits-1:0]   p2_ff, p2_in;
   logic                         neg_ff, neg_in;
   logic                         pend_valid_ff, pend_valid_in;
   result_type                   pend_ff, pend_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   result_type                   rsp_ff, rsp_in;

   logic [RateBits-1:0]          rin, rout;
   logic [RateBits-1:0]          weight_prev;
   logic signed [RateBits:0]     weight_prev_s, weight_cur_s;
   logic signed [ProdBits-1:0]   num;
   logic signed [ProdBits-1:0]   num_abs;
   logic                         div_start;
   logic                         div_busy;
   logic [QuotBits-1:0]          quot;
   logic signed [SampleBits-1:0] mag;
   result_type                   interp_res, copy_res, marker_res, error_res;
   logic                         out_free;
   logic                         below_out;
   logic                         copy_fits;
   logic                         room;
   logic [PhaseBits-1:0]         phase_step;

   assign rin  = cfg.in_rate;
   assign rout = cfg.out_rate;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign below_out  = (phase_ff < PhaseBits'(rout));
   assign copy_fits  = ({1'b0, phase_ff} + (PhaseBits+1)'(rin)) <= (PhaseBits+1)'(rout);
   assign room       = (count_ff < CountBits'(MaxResults));
   assign phase_step = phase_ff + PhaseBits'(rin);

   // Weights of the two neighbors; the phase is below rout inside the loop.
   assign weight_prev   = rout - phase_ff[RateBits-1:0];
   assign weight_prev_s = signed'({1'b0, weight_prev});
   assign weight_cur_s  = signed'({1'b0, phase_ff[RateBits-1:0]});

   assign num     = p1_ff + p2_ff;
   assign num_abs = num[ProdBits-1] ? -num : num;

   plir_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_abs[MagBits-1:0]),
      .divisor  (rout),
      .busy     (div_busy),
      .quotient (quot)
   );

   // The quotient is truncated toward zero; clamp, then restore the sign.
   assign mag = (quot > QuotBits'(SampleMax)) ? SampleMax : signed'(quot);

   always_comb begin
      interp_res.sample_out   = neg_ff ? -mag : mag;
      interp_res.sample_valid = 1'b1;
      interp_res.rate_error   = 1'b0;
      interp_res.last_out     = 1'b0;

      copy_res.sample_out   = (cur_ff == SampleMin) ? -SampleMax : cur_ff;
      copy_res.sample_valid = 1'b1;
      copy_res.rate_error   = 1'b0;
      copy_res.last_out     = 1'b0;

      marker_res.sample_out   = '0;
      marker_res.sample_valid = 1'b0;
      marker_res.rate_error   = 1'b0;
      marker_res.last_out     = 1'b1;

      error_res.sample_out   = '0;
      error_res.sample_valid = 1'b0;
      error_res.rate_error   = 1'b1;
      error_res.last_out     = 1'b0;
   end

   // The newest result is held back one place, so that last_out can be
   // set on it once the item turns out to give no further result.
   always_comb begin
      state_in      = state_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      have_in       = have_ff;
      end_in        = end_ff;
      phase_in      = phase_ff;
      count_in      = count_ff;
      p1_in         = p1_ff;
      p2_in         = p2_ff;
      neg_in        = neg_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_in        = rsp_ff;
      q_pop         = 1'b0;
      div_start     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cur_in   = q_item.sample;
               end_in   = q_item.stream_end;
               count_in = '0;
               if (q_item.rate_error) begin
                  pend_in       = error_res;
                  pend_valid_in = 1'b1;
                  count_in      = CountBits'(1);
                  if (q_item.stream_end) begin
                     have_in  = 1'b0;
                     phase_in = '0;
                  end
                  state_in = S_FINISH;
               end else if (have_ff) begin
                  state_in = S_CHECK;
               end else begin
                  phase_in = '0;
                  prev_in  = q_item.sample;
                  have_in  = 1'b1;
                  state_in = q_item.stream_end ? S_COPY : S_FINISH;
               end
            end
         end

         S_CHECK: begin
            if (below_out) begin
               if (room) begin
                  p1_in    = prev_ff * weight_prev_s;
                  p2_in    = cur_ff * weight_cur_s;
                  state_in = S_SUM;
               end else begin
                  // Result limit reached: the phase still walks on.
                  phase_in = phase_step;
               end
            end else begin
               phase_in = phase_ff - PhaseBits'(rout);
               prev_in  = cur_ff;
               have_in  = 1'b1;
               state_in = end_ff ? S_COPY : S_FINISH;
            end
         end

         S_SUM: begin
            neg_in    = num[ProdBits-1];
            div_start = 1'b1;
            state_in  = S_DIV;
         end

         S_DIV: begin
            if (!div_busy && (!pend_valid_ff || out_free)) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = pend_ff;
               end
               pend_in       = interp_res;
               pend_valid_in = 1'b1;
               count_in      = count_ff + CountBits'(1);
               phase_in      = phase_step;
               state_in      = S_CHECK;
            end
         end

         S_COPY: begin
            if (copy_fits) begin
               if (!room) begin
                  phase_in = phase_step;
               end else if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = pend_ff;
                  end
                  pend_in       = copy_res;
                  pend_valid_in = 1'b1;
                  count_in      = count_ff + CountBits'(1);
                  phase_in      = phase_step;
               end
            end else begin
               have_in  = 1'b0;
               phase_in = '0;
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            if (pend_valid_ff) begin
               if (out_free) begin
                  rsp_valid_in    = 1'b1;
                  rsp_in          = pend_ff;
                  rsp_in.last_out = 1'b1;
                  pend_valid_in   = 1'b0;
                  state_in        = S_IDLE;
               end
            end else if (end_ff) begin
               // End of stream with nothing emitted: a bare marker word.
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = marker_res;
                  state_in     = S_IDLE;
               end
            end else begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         have_ff       <= 1'b0;
         phase_ff      <= '0;
         prev_ff       <= '0;
         count_ff      <= '0;
         end_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         have_ff       <= have_in;
         phase_ff      <= phase_in;
         prev_ff       <= prev_in;
         count_ff      <= count_in;
         end_ff        <= end_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      neg_ff  <= neg_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.sample_out;
   assign rsp_tuser  = {rsp_ff.rate_error, rsp_ff.sample_valid};
   assign rsp_tlast  = rsp_ff.last_out;

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountBits'(MaxResults))
      else $error("result count exceeds the per-word limit");

   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !pend_valid_ff)
      else $error("held result left behind at end of word");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.rate_error |-> rsp_ff.last_out && !rsp_ff.sample_valid)
      else $error("rate error word is not a lone final word");

   a_marker_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.sample_valid |-> rsp_ff.last_out)
      else $error("non-sample word is not marked last");

endmodule

// ----- bench/plir_resample_checker.sv -----
`timescale 1ns / 1ps

module plir_resample_checker import plir_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [SampleBits-1:0] req_tdata,   // sample_in
   input  logic                  req_tlast,   // stream_end
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [SampleBits-1:0] rsp_tdata,   // sample_out
   input  logic [1:0]            rsp_tuser,   // sample_valid, rate_error
   input  logic                  rsp_tlast,   // last_out
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [AddrBits-1:0]   csr_paddr,
   input  logic [DataBits-1:0]   csr_pwdata,
   input  logic                  csr_pready,
   output int unsigned           error_count,
   output int unsigned           pending_count
);

   localparam logic [AddrBits-1:0] InRateAddr  = {RegInRate, 2'b00};
   localparam logic [AddrBits-1:0] OutRateAddr = {RegOutRate, 2'b00};

   result_type expected_samples [$];
   result_type word_results [$];

   logic [RateBits-1:0]          in_rate;
   logic [RateBits-1:0]          out_rate;
   logic signed [SampleBits-1:0] held_sample;
   logic                         held_valid;
   int unsigned                  phase;

   function automatic logic supported_rate(input logic [RateBits-1:0] rate);
      case (rate)
         18'd8000, 18'd11025, 18'd16000, 18'd22050, 18'd32000, 18'd44100,
         18'd48000, 18'd88200, 18'd96000, 18'd176400, 18'd192000: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // Clamps symmetrically, so negative full scale comes out one step smaller.
   // Anything past the result limit of one word is dropped here.
   task automatic emit(input longint value, input logic valid, input logic err);
      result_type r;
      longint     v;
      v = value;
      if (v > longint'(SampleMax)) begin
         v = longint'(SampleMax);
      end
      if (v < -longint'(SampleMax)) begin
         v = -longint'(SampleMax);
      end
      r.sample_out   = SampleBits'(v);
      r.sample_valid = valid;
      r.rate_error   = err;
      r.last_out     = 1'b0;
      if (word_results.size() < MaxResults) begin
         word_results = {word_results, r};
      end
   endtask

   task automatic interpolate_word(input logic signed [SampleBits-1:0] cur,
                                   input logic fin);
      int unsigned rin;
      int unsigned rout;
      longint      weighted;
      rin  = in_rate;
      rout = out_rate;
      word_results.delete();
      if (!supported_rate(out_rate) || rin == 0) begin
         emit(0, 1'b0, 1'b1);
         if (fin) begin
            held_valid = 1'b0;
            phase      = 0;
         end
      end else begin
         if (held_valid) begin
            while (phase < rout) begin
               weighted = longint'(held_sample) * longint'(rout - phase)
                        + longint'(cur) * longint'(phase);
               emit(weighted / longint'(rout), 1'b1, 1'b0);
               phase += rin;
            end
            phase -= rout;
         end else begin
            phase = 0;
         end
         held_sample = cur;
         held_valid  = 1'b1;
         if (fin) begin
            // Pad the tail of the stream with copies of the final sample.
            while (phase + rin <= rout) begin
               emit(longint'(cur), 1'b1, 1'b0);
               phase += rin;
            end
            held_valid = 1'b0;
            phase      = 0;
            if (word_results.size() == 0) begin
               emit(0, 1'b0, 1'b0);
            end
         end
      end
      if (word_results.size() > 0) begin
         word_results[word_results.size() - 1].last_out = 1'b1;
      end
      expected_samples = {expected_samples, word_results};
   endtask

   always @(posedge clock) begin : monitor
      result_type exp_word;
      if (reset) begin
         expected_samples.delete();
         in_rate     = InRateReset;
         out_rate    = OutRateReset;
         held_sample = '0;
         held_valid  = 1'b0;
         phase       = 0;
         error_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == InRateAddr) begin
               in_rate = csr_pwdata[RateBits-1:0];
            end else if (csr_paddr == OutRateAddr) begin
               out_rate = csr_pwdata[RateBits-1:0];
            end
         end
         if (req_tvalid && req_tready) begin
            interpolate_word(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_samples.size() == 0) begin
               $error("unexpected word: sample_out %0d, tuser %b, tlast %b",
                      $signed(rsp_tdata), rsp_tuser, rsp_tlast);
               error_count++;
            end else begin
               exp_word = expected_samples.pop_front();
               if (rsp_tdata !== exp_word.sample_out) begin
                  $error("sample_out: expected %0d, got %0d",
                         exp_word.sample_out, $signed(rsp_tdata));
                  error_count++;
               end
               if (rsp_tuser[0] !== exp_word.sample_valid) begin
                  $error("sample_valid: expected %0d, got %0d",
                         exp_word.sample_valid, rsp_tuser[0]);
                  error_count++;
               end
               if (rsp_tuser[1] !== exp_word.rate_error) begin
                  $error("rate_error: expected %0d, got %0d",
                         exp_word.rate_error, rsp_tuser[1]);
                  error_count++;
               end
               if (rsp_tlast !== exp_word.last_out) begin
                  $error("last_out: expected %0d, got %0d",
                         exp_word.last_out, rsp_tlast);
                  error_count++;
               end
            end
         end
      end
      pending_count = expected_samples.size();
   end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import plir_pkg::*;

   localparam int     ClockPeriod  = 12;
   localparam int     ResetCycles  = 8;
   localparam int     DrainCycles  = 64;
   localparam int     EndWaitLimit = 200000;
   localparam longint RunLimitNs   = 64'd200_000_000;
   localparam int     NumSegments  = 9;

   localparam logic [AddrBits-1:0] InRateAddr  = {RegInRate, 2'b00};
   localparam logic [AddrBits-1:0] OutRateAddr = {RegOutRate, 2'b00};

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [SampleBits-1:0] req_tdata;   // sample_in
   logic                  req_tlast;   // stream_end
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [SampleBits-1:0] rsp_tdata;   // sample_out
   logic [1:0]            rsp_tuser;   // sample_valid, rate_error
   logic                  rsp_tlast;   // last_out
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [AddrBits-1:0]   csr_paddr;
   logic [DataBits-1:0]   csr_pwdata;
   logic [DataBits-1:0]   csr_prdata;
   logic                  csr_pready;

   int unsigned error_count;
   int unsigned pending_count;
   int          req_idle_pct = 27;
   int          rsp_idle_pct = 51;
   int          stream_left  = 0;

   always #(ClockPeriod / 2) clock = ~clock;

   pcm_linear_interp_resampler dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   plir_resample_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= rsp_idle_pct);
   end

   // All tasks below start and end at a falling edge.
   task automatic send_word(input logic [SampleBits-1:0] smp, input logic fin);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid = 1'b0;
         req_tdata  = SampleBits'($urandom);
         req_tlast  = 1'($urandom);
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = smp;
      req_tlast  = fin;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [AddrBits-1:0] addr,
                            input logic [DataBits-1:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = addr;
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // A word may produce no result, so the block can still be busy once the
   // last expected result is in; give it time before touching the rates.
   task automatic set_rates(input int unsigned rin, input int unsigned rout,
                            input logic junk_high);
      req_tvalid = 1'b0;
      while (pending_count != 0) begin
         @(negedge clock);
      end
      repeat (DrainCycles) @(negedge clock);
      write_reg(InRateAddr,
                junk_high ? {14'($urandom), RateBits'(rin)} : DataBits'(rin));
      write_reg(OutRateAddr,
                junk_high ? {14'($urandom), RateBits'(rout)} : DataBits'(rout));
   endtask

   function automatic logic [SampleBits-1:0] random_sample();
      case ($urandom_range(9))
         0: return SampleMax;
         1: return SampleMin;
         2: return SampleBits'(int'($urandom_range(32)) - 16);
         default: return SampleBits'($urandom);
      endcase
   endfunction

   // Mostly whole streams of random length, with an occasional stray end.
   task automatic send_stream_word();
      logic fin;
      if (stream_left == 0) begin
         stream_left = $urandom_range(1, 8);
      end
      fin = (stream_left == 1) || ($urandom_range(19) == 0);
      stream_left = fin ? 0 : stream_left - 1;
      send_word(random_sample(), fin);
   endtask

   function automatic int unsigned std_rate();
      return StdRates[$urandom_range(NumStdRates - 1)];
   endfunction

   initial begin
      int unsigned rin;
      int unsigned rout;
      int          words;
      int          waited;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (ResetCycles) @(negedge clock);
      reset = 1'b0;

      // Rates straight out of reset: equal, so a pass-through delayed by one
      // word, including the saturation of negative full scale.
      send_word(SampleMax, 1'b0);
      send_word(SampleMin, 1'b0);
      send_word(SampleMin, 1'b0);
      send_word('0, 1'b0);
      send_word('1, 1'b1);

      // Widest upsampling, swinging between the two extremes.
      set_rates(8000, 192000, 1'b0);
      send_word(SampleMin, 1'b0);
      send_word(SampleMax, 1'b0);
      send_word(SampleMin, 1'b1);

      // Widest downsampling; a lone sample with its end flag gives a marker.
      set_rates(192000, 8000, 1'b0);
      send_word(16'sd100, 1'b1);
      send_word(SampleMax, 1'b0);
      send_word(-16'sd7, 1'b0);
      send_word(16'sd12345, 1'b0);
      send_word(SampleMin, 1'b1);

      // Input rate below the lowest standard one overflows the result limit.
      set_rates(1000, 192000, 1'b0);
      send_word(SampleMax, 1'b0);
      send_word(SampleMin, 1'b0);
      send_word(16'sd1, 1'b1);

      // Output rate that is not a standard one, then a zero input rate.
      set_rates(16000, 12345, 1'b0);
      send_word(16'sd5, 1'b0);
      send_word(-16'sd5, 1'b1);
      set_rates(0, 8000, 1'b0);
      send_word(16'sd9, 1'b0);
      send_word(16'sd9, 1'b1);

      for (int seg = 0; seg < NumSegments; seg++) begin
         words = 12;
         case (seg)
            0: begin rin = 44100; rout = 48000; end
            1: begin rin = 48000; rout = 44100; end
            2: begin rin = std_rate(); rout = std_rate(); end
            3: begin rin = 262143; rout = 8000; end
            4: begin rin = $urandom_range(1, 7999); rout = 192000; words = 6; end
            5: begin rin = std_rate(); rout = $urandom_range(0, 262143); end
            6: begin rin = 192000; rout = 192000; end
            7: begin rin = $urandom_range(1, 262143); rout = std_rate(); end
            default: begin rin = 8000; rout = 192000; end
         endcase
         set_rates(rin, rout, 1'b1);
         if (seg < 3) begin
            req_idle_pct = 27;
            rsp_idle_pct = 51;
         end else if (seg < 6) begin
            req_idle_pct = 51;
            rsp_idle_pct = 27;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         repeat (words) send_stream_word();
      end
      req_tvalid = 1'b0;

      waited = 0;
      while (pending_count != 0 && waited < EndWaitLimit) begin
         @(negedge clock);
         waited++;
      end
      repeat (DrainCycles) @(negedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   initial begin
      #(RunLimitNs);
      $display("tb_top: done, errors");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/plir_pkg.sv
design/plir_csr.sv
design/plir_front.sv
design/plir_div.sv
design/plir_back.sv
design/pcm_linear_interp_resampler.sv
bench/plir_resample_checker.sv
bench/tb_top.sv
